@@ rtl/rpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio power request arbiter package
// Shared types, action codes, field widths and reset values for the arbiter.
// ----------------------------------------------------------------------------
package rpa_pkg;

	// Default number of voting requesters and reset value of the retry delay.
	localparam int unsigned NUM_REQUESTERS_DEF = 8;
	localparam logic [15:0] RETRY_DELAY_RESET  = 16'd1000;

	// Field widths.
	localparam int unsigned ACTION_W    = 3;
	localparam int unsigned REQUESTER_W = 3;
	localparam int unsigned RSTATE_W    = 4;
	localparam int unsigned DELAY_W     = 16;

	// Radio state codes that carry a meaning of their own.
	localparam logic [RSTATE_W-1:0] RSTATE_OFF         = 4'd0;
	localparam logic [RSTATE_W-1:0] RSTATE_UNAVAILABLE = 4'd1;

	// Input actions.
	typedef enum logic [ACTION_W-1:0] {
		ACT_VOTE_ON      = 3'd0,
		ACT_VOTE_OFF     = 3'd1,
		ACT_CONFIRM_ON   = 3'd2,
		ACT_POWER_CYCLE  = 3'd3,
		ACT_REQUEST_DONE = 3'd4,
		ACT_TICK         = 3'd5,
		ACT_STATE_REPORT = 3'd6
	} action_t;

	// One input item.
	typedef struct packed {
		logic [ACTION_W-1:0]    action;
		logic [REQUESTER_W-1:0] requester;
		logic [RSTATE_W-1:0]    reported_state;
	} item_t;

	// Arbiter state apart from the vote mask, plus the per-item event flags.
	typedef struct packed {
		logic                  pending;
		logic                  target_on;
		logic                  queued;
		logic                  changed_while_pending;
		logic [DELAY_W-1:0]    retry_count;
		logic                  retry_active;
		logic                  cycle;
		logic [RSTATE_W-1:0]   last_state;
		logic [RSTATE_W-1:0]   shown_state;
		logic                  send;
		logic                  send_on;
		logic                  changed;
	} arb_t;

	// One result item.
	typedef struct packed {
		logic                power_wanted;
		logic                cycle_in_progress;
		logic                retry_armed;
		logic                request_pending;
		logic [RSTATE_W-1:0] public_state;
		logic                state_changed;
		logic                request_on;
		logic                send_request;
	} result_t;

	// Issue a new power request at the given level.
	function automatic arb_t arb_submit(arb_t s, logic on);
		arb_t r;
		r                       = s;
		r.queued                = 1'b0;
		r.target_on             = on;
		r.changed_while_pending = 1'b0;
		r.retry_active          = 1'b0;
		r.retry_count           = '0;
		r.pending               = 1'b1;
		r.send                  = 1'b1;
		r.send_on               = on;
		return r;
	endfunction

	// Request a level: queue it behind a pending request or issue it now.
	function automatic arb_t arb_request(arb_t s, logic on, logic repeat_ok);
		arb_t r;
		r = s;
		if (s.pending) begin
			if (repeat_ok || (s.target_on != on)) begin
				r.queued    = 1'b1;
				r.target_on = on;
			end
		end else begin
			r = arb_submit(s, on);
		end
		return r;
	endfunction

	// Compare the reported state with the wanted one and publish when settled.
	function automatic arb_t arb_check(arb_t s, logic votes_held, logic [DELAY_W-1:0] delay);
		arb_t r;
		logic wanted;
		r      = s;
		wanted = votes_held && !s.cycle;
		if (!r.pending) begin
			if ((r.last_state != RSTATE_OFF) == wanted) begin
				r.retry_active = 1'b0;
				r.retry_count  = '0;
			end else if (r.changed_while_pending) begin
				r = arb_submit(r, wanted);
			end else if (!r.retry_active) begin
				r.retry_active = 1'b1;
				r.retry_count  = (delay != '0) ? delay : DELAY_W'(1);
			end
		end
		if (!r.pending && !r.retry_active && (r.shown_state != r.last_state)) begin
			r.shown_state = r.last_state;
			r.changed     = 1'b1;
		end
		return r;
	endfunction

endpackage

@@ rtl/rpa_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arbiter input register
// Holds one accepted input item until the update logic takes it.
// ----------------------------------------------------------------------------
module rpa_in_stage import rpa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  valid_s1,
	output item_t item_s1,
	input  logic  take
);

	// The register refills in the same cycle that its item is taken.
	assign in_ready = !valid_s1 || take;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the input register.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ rtl/rpa_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arbiter update core
// Applies one item to the vote mask and request state and registers the result.
// ----------------------------------------------------------------------------
module rpa_core import rpa_pkg::*; #(
	parameter int unsigned NUM_REQUESTERS = NUM_REQUESTERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [DELAY_W-1:0] cfg_wdata,
	input  logic               valid_s1,
	input  item_t              item_s1,
	output logic               take,
	output logic               out_valid,
	input  logic               out_ready,
	output result_t            out_result
);

	logic [NUM_REQUESTERS-1:0] votes_q;
	logic [NUM_REQUESTERS-1:0] votes_nxt;
	logic [NUM_REQUESTERS-1:0] req_hit;
	logic [DELAY_W-1:0]        delay_q;
	arb_t                      arb_q;
	arb_t                      arb_nxt;
	result_t                   result_nxt;
	logic                      out_valid_q;
	result_t                   out_result_q;

	// An item moves on when the result register is free or being drained.
	assign take = valid_s1 && (!out_valid_q || out_ready);

	// One-hot decode of the requester; an index beyond the set hits nothing.
	always_comb begin
		for (int i = 0; i < NUM_REQUESTERS; i++) begin
			req_hit[i] = (32'(item_s1.requester) == 32'(i));
		end
	end

	// Next arbiter state for the item in the input register.
	always_comb begin
		logic was_wanted;
		arb_nxt         = arb_q;
		arb_nxt.send    = 1'b0;
		arb_nxt.send_on = 1'b0;
		arb_nxt.changed = 1'b0;
		votes_nxt       = votes_q;
		was_wanted      = (votes_q != '0) && !arb_q.cycle;
		case (action_t'(item_s1.action))
			ACT_VOTE_ON: begin
				if ((req_hit != '0) && ((votes_q & req_hit) == '0)) begin
					votes_nxt = votes_q | req_hit;
					if (!was_wanted) begin
						arb_nxt = arb_request(arb_nxt, 1'b1, 1'b0);
					end
				end
			end
			ACT_VOTE_OFF: begin
				if ((votes_q & req_hit) != '0) begin
					votes_nxt = votes_q & ~req_hit;
					if (!((votes_nxt != '0) && !arb_q.cycle)) begin
						arb_nxt = arb_request(arb_nxt, 1'b0, 1'b0);
					end
				end
			end
			ACT_CONFIRM_ON: begin
				if (was_wanted) begin
					arb_nxt = arb_request(arb_nxt, 1'b1, 1'b1);
				end
			end
			ACT_POWER_CYCLE: begin
				if ((arb_q.last_state != RSTATE_OFF) && !arb_q.cycle) begin
					arb_nxt.cycle = 1'b1;
					if (!arb_q.pending) begin
						arb_nxt = arb_submit(arb_nxt, 1'b0);
					end
				end
			end
			ACT_REQUEST_DONE: begin
				if (arb_q.pending) begin
					arb_nxt.pending = 1'b0;
					if (arb_q.queued) begin
						arb_nxt = arb_submit(arb_nxt, arb_q.target_on);
					end else begin
						arb_nxt = arb_check(arb_nxt, votes_q != '0, delay_q);
					end
				end
			end
			ACT_TICK: begin
				if (arb_q.retry_active) begin
					if (arb_q.retry_count != '0) begin
						arb_nxt.retry_count = arb_q.retry_count - DELAY_W'(1);
					end
					if (arb_nxt.retry_count == '0) begin
						arb_nxt.retry_active = 1'b0;
						arb_nxt = arb_submit(arb_nxt, was_wanted);
					end
				end
			end
			ACT_STATE_REPORT: begin
				if (item_s1.reported_state != RSTATE_UNAVAILABLE) begin
					if (arb_q.cycle && (item_s1.reported_state == RSTATE_OFF)) begin
						arb_nxt.cycle = 1'b0;
					end
					if (arb_q.pending) begin
						arb_nxt.changed_while_pending = 1'b1;
					end
					arb_nxt.last_state = item_s1.reported_state;
					arb_nxt = arb_check(arb_nxt, votes_q != '0, delay_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Result fields as the state stands after the item.
	always_comb begin
		result_nxt.send_request      = arb_nxt.send;
		result_nxt.request_on        = arb_nxt.send_on;
		result_nxt.state_changed     = arb_nxt.changed;
		result_nxt.public_state      = arb_nxt.shown_state;
		result_nxt.request_pending   = arb_nxt.pending;
		result_nxt.retry_armed       = arb_nxt.retry_active;
		result_nxt.cycle_in_progress = arb_nxt.cycle;
		result_nxt.power_wanted      = (votes_nxt != '0) && !arb_nxt.cycle;
	end

	// Arbiter state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arb_q   <= '0;
			votes_q <= '0;
		end else if (take) begin
			arb_q   <= arb_nxt;
			votes_q <= votes_nxt;
		end
	end

	// Retry delay register; the user must write it only while the block is idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= RETRY_DELAY_RESET;
		end else if (cfg_we) begin
			delay_q <= cfg_wdata;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (take) begin
			out_result_q <= result_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_result_q;

endmodule

@@ rtl/radio_power_request_arbiter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio power request arbiter
// Collects power votes, keeps one power request outstanding and publishes
// the radio state once the radio has settled.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled and
// returns exactly one result for each: an item passes through the input register
// and then through the update logic into the result register. The rate is set
// by that single update pass, which reads and writes all arbiter state. There is
// no clearing pass after reset. The user must write the retry delay through
// cfg_we and cfg_wdata only while no item is in flight; the block does not
// enforce this. A delay of zero behaves as one tick.
module radio_power_request_arbiter import rpa_pkg::*; #(
	parameter int unsigned NUM_REQUESTERS = NUM_REQUESTERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write: retry delay in ticks.
	input  logic               cfg_we,
	input  logic [DELAY_W-1:0] cfg_wdata,
	// Input stream.
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,  // requester[2:0], reported_state[6:3], zero[7]
	input  logic [2:0]         s_tuser,  // action[2:0]
	// Result stream.
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata   // send_request[0], request_on[1],
	                                     // state_changed[2], public_state[6:3],
	                                     // request_pending[7], retry_armed[8],
	                                     // cycle_in_progress[9], power_wanted[10],
	                                     // zero[15:11]
);

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    take;
	result_t out_result;

	// Unpack the input transfer.
	assign in_item.action         = s_tuser;
	assign in_item.requester      = s_tdata[2:0];
	assign in_item.reported_state = s_tdata[6:3];

	rpa_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take)
	);

	rpa_core #(
		.NUM_REQUESTERS (NUM_REQUESTERS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.take       (take),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

	// Pack the result transfer.
	assign m_tdata = {5'b0, out_result};

endmodule
